FILE: hdl/pli_pkg.sv
// Package for the positional list block: field widths, operation and status codes.
// Used by the channel interfaces and by the top level. Depends on nothing.
package pli_pkg;

  localparam int FUNC_WIDTH     = 2;
  localparam int POSITION_WIDTH = 9;
  localparam int VALUE_WIDTH    = 32;
  localparam int STATUS_WIDTH   = 2;
  localparam int LENGTH_WIDTH   = 9;

  localparam int DEFAULT_CAPACITY      = 256;
  localparam int DEFAULT_ELEMENT_WIDTH = 32;

  typedef enum logic [FUNC_WIDTH-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STATUS_OK           = 2'd0,
    STATUS_BAD_POSITION = 2'd1,
    STATUS_FULL         = 2'd2
  } status_t;

endpackage

FILE: hdl/pli_req_if.sv
// Request channel of the positional list block: valid, ready and one operation item.
// Depends on pli_pkg.
interface pli_req_if;
  logic                                      valid;
  logic                                      ready;
  pli_pkg::func_t                            func;
  logic        [pli_pkg::POSITION_WIDTH-1:0] position;
  logic signed [pli_pkg::VALUE_WIDTH-1:0]    value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink (input valid, input func, input position, input value, output ready);
endinterface

FILE: hdl/pli_rsp_if.sv
// Result channel of the positional list block: valid, ready and one result item.
// Depends on pli_pkg.
interface pli_rsp_if;
  logic                                    valid;
  logic                                    ready;
  pli_pkg::status_t                        status;
  logic signed [pli_pkg::VALUE_WIDTH-1:0]  element;
  logic        [pli_pkg::LENGTH_WIDTH-1:0] list_length;

  modport source (output valid, output status, output element, output list_length, input ready);
  modport sink (input valid, input status, input element, input list_length, output ready);
endinterface

FILE: hdl/positional_list_insert_delete_core.sv
// Top level of the positional list block: sequencer, list memory and result register.
// Depends on pli_pkg, pli_req_if and pli_rsp_if.
//
// The req channel carries one operation item (insert, delete, read or clear) with a
// 1-based position and a value; the rsp channel returns one result item per request
// with a status, the deleted or read element and the list length afterwards.
// Items are handled one at a time; req.ready is high only while the sequencer is idle.
// The list lives in a single-port-write, single-port-read memory of CAPACITY words
// with a registered read port, and entries are shifted through it one per cycle.
// An insert that shifts runs the shift, tail and put states; an append goes to put
// alone; a delete runs the shift and tail states; a read issues and then grabs the
// word; a clear or a rejected request goes straight to finish. The longest are the
// shifting insert and delete, which loop over the entries behind the position.
// The result sits in an output register, so the sequencer finishes its work while a
// stalled receiver holds the previous result; it waits only to hand over the next one.
// A synchronous reset empties the list at once; the memory itself is not cleared,
// since no entry beyond the length can be read.
module positional_list_insert_delete_core #(
  parameter int CAPACITY      = pli_pkg::DEFAULT_CAPACITY,
  parameter int ELEMENT_WIDTH = pli_pkg::DEFAULT_ELEMENT_WIDTH
) (
  input logic      clk,
  input logic      rst,
  pli_req_if.sink   req,
  pli_rsp_if.source rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > pli_pkg::POSITION_WIDTH) ? CW : pli_pkg::POSITION_WIDTH) + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_TAIL,
    S_INS_PUT,
    S_DEL_SHIFT,
    S_DEL_TAIL,
    S_RD_ISSUE,
    S_RD_GRAB,
    S_FINISH
  } state_t;

  state_t                               state;
  logic   [CW-1:0]                      count;
  logic   [AW-1:0]                      rp;
  logic   [AW-1:0]                      wp;
  logic   [AW-1:0]                      pidx;
  logic   [ELEMENT_WIDTH-1:0]           val_r;
  logic                                 primed;
  logic                                 first;
  pli_pkg::status_t                     st_w;
  logic   [pli_pkg::VALUE_WIDTH-1:0]    elem_w;
  logic                                 out_valid;
  pli_pkg::status_t                     out_status;
  logic   [pli_pkg::VALUE_WIDTH-1:0]    out_element;
  logic   [pli_pkg::LENGTH_WIDTH-1:0]   out_length;

  logic [ELEMENT_WIDTH-1:0] mem [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] rdata;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [ELEMENT_WIDTH-1:0] wr_data;

  logic [PW-1:0]            pos_x;
  logic [PW-1:0]            cnt_x;
  logic [AW-1:0]            pos_idx;
  logic [AW-1:0]            last_idx;
  logic                     ins_ok;
  logic                     hit_ok;
  logic                     full;
  logic                     append;
  logic [ELEMENT_WIDTH-1:0] store_val;

  assign pos_x     = PW'(req.position);
  assign cnt_x     = PW'(count);
  assign pos_idx   = AW'(pos_x - PW'(1));
  assign last_idx  = AW'(cnt_x - PW'(1));
  assign ins_ok    = (pos_x != '0) && (pos_x <= cnt_x + PW'(1));
  assign hit_ok    = (pos_x != '0) && (pos_x <= cnt_x);
  assign full      = (cnt_x == PW'(CAPACITY));
  assign append    = (pos_x == cnt_x + PW'(1));
  assign store_val = ELEMENT_WIDTH'({{(64 - pli_pkg::VALUE_WIDTH){req.value[31]}}, req.value});

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.element     = out_element;
  assign rsp.list_length = out_length;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wp;
    wr_data = rdata;
    case (state)
      S_INS_SHIFT: begin
        wr_en = primed;
      end
      S_INS_TAIL: begin
        wr_en = 1'b1;
      end
      S_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pidx;
        wr_data = val_r;
      end
      S_DEL_SHIFT, S_DEL_TAIL: begin
        wr_en = primed && !first;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      primed    <= 1'b0;
      first     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            elem_w <= '0;
            primed <= 1'b0;
            first  <= 1'b1;
            pidx   <= pos_idx;
            val_r  <= store_val;
            case (req.func)
              pli_pkg::FUNC_INSERT: begin
                if (!ins_ok) begin
                  st_w  <= pli_pkg::STATUS_BAD_POSITION;
                  state <= S_FINISH;
                end else if (full) begin
                  st_w  <= pli_pkg::STATUS_FULL;
                  state <= S_FINISH;
                end else if (append) begin
                  st_w  <= pli_pkg::STATUS_OK;
                  state <= S_INS_PUT;
                end else begin
                  st_w  <= pli_pkg::STATUS_OK;
                  rp    <= last_idx;
                  state <= S_INS_SHIFT;
                end
              end
              pli_pkg::FUNC_DELETE: begin
                if (!hit_ok) begin
                  st_w  <= pli_pkg::STATUS_BAD_POSITION;
                  state <= S_FINISH;
                end else begin
                  st_w  <= pli_pkg::STATUS_OK;
                  rp    <= pos_idx;
                  state <= S_DEL_SHIFT;
                end
              end
              pli_pkg::FUNC_READ: begin
                if (!hit_ok) begin
                  st_w  <= pli_pkg::STATUS_BAD_POSITION;
                  state <= S_FINISH;
                end else begin
                  st_w  <= pli_pkg::STATUS_OK;
                  rp    <= pos_idx;
                  state <= S_RD_ISSUE;
                end
              end
              pli_pkg::FUNC_CLEAR: begin
                st_w  <= pli_pkg::STATUS_OK;
                count <= '0;
                state <= S_FINISH;
              end
              default: begin
                st_w  <= pli_pkg::STATUS_OK;
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_INS_SHIFT: begin
          wp     <= rp + AW'(1);
          primed <= 1'b1;
          if (rp == pidx) begin
            state <= S_INS_TAIL;
          end else begin
            rp <= rp - AW'(1);
          end
        end
        S_INS_TAIL: begin
          state <= S_INS_PUT;
        end
        S_INS_PUT: begin
          count <= count + CW'(1);
          state <= S_FINISH;
        end
        S_DEL_SHIFT: begin
          if (primed && first) begin
            elem_w <= pli_pkg::VALUE_WIDTH'(rdata);
            first  <= 1'b0;
          end
          wp     <= rp - AW'(1);
          primed <= 1'b1;
          if (rp == last_idx) begin
            state <= S_DEL_TAIL;
          end else begin
            rp <= rp + AW'(1);
          end
        end
        S_DEL_TAIL: begin
          if (first) begin
            elem_w <= pli_pkg::VALUE_WIDTH'(rdata);
          end
          count <= count - CW'(1);
          state <= S_FINISH;
        end
        S_RD_ISSUE: begin
          state <= S_RD_GRAB;
        end
        S_RD_GRAB: begin
          elem_w <= pli_pkg::VALUE_WIDTH'(rdata);
          state  <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_status  <= st_w;
            out_element <= elem_w;
            out_length  <= pli_pkg::LENGTH_WIDTH'(count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_x <= PW'(CAPACITY))
    else $error("list length above capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in progress");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_PUT) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the list by one");

  a_full_length: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == pli_pkg::STATUS_FULL)
      |-> (rsp.list_length == pli_pkg::LENGTH_WIDTH'(CAPACITY)))
    else $error("full status with a list that is not full");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_FINISH) |-> !wr_en)
    else $error("memory written outside a list operation");

endmodule

FILE: sim/positional_list_insert_delete_core_tb.sv
// Testbench for the positional list block: directed, full-list, stall and random tests,
// each result checked against a local model of the list. Depends on pli_pkg, pli_req_if,
// pli_rsp_if and positional_list_insert_delete_core.
module positional_list_insert_delete_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_CAPACITY = pli_pkg::DEFAULT_CAPACITY;
  localparam int RUN_LIMIT_NS  = 3_000_000;

  typedef struct packed {
    pli_pkg::status_t                       status;
    logic signed [pli_pkg::VALUE_WIDTH-1:0] element;
    logic [pli_pkg::LENGTH_WIDTH-1:0]       list_length;
  } list_result_t;

  logic clk;
  logic rst;

  pli_req_if req ();
  pli_rsp_if rsp ();

  positional_list_insert_delete_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  logic signed [pli_pkg::VALUE_WIDTH-1:0] list_words [LIST_CAPACITY];
  int                                     list_len;
  list_result_t                           pending_results [$];
  list_result_t                           due;
  int                                     error_count;
  int                                     items_sent;
  int                                     results_checked;
  int                                     hold_off_cycles;
  bit                                     no_idle;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("TB_ERROR");
    $finish;
  end

  task automatic flag_mismatch(string msg);
    error_count++;
    if (error_count <= 40) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
  endtask

  function automatic list_result_t apply_list_op(pli_pkg::func_t op,
                                                 logic [pli_pkg::POSITION_WIDTH-1:0] pos,
                                                 logic signed [pli_pkg::VALUE_WIDTH-1:0] val);
    list_result_t r;
    int p;
    p = int'(pos);
    r.status  = pli_pkg::STATUS_OK;
    r.element = '0;
    case (op)
      pli_pkg::FUNC_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          r.status = pli_pkg::STATUS_BAD_POSITION;
        end else if (list_len >= LIST_CAPACITY) begin
          r.status = pli_pkg::STATUS_FULL;
        end else begin
          for (int k = list_len; k >= p; k--) list_words[k] = list_words[k-1];
          list_words[p-1] = val;
          list_len++;
        end
      end
      pli_pkg::FUNC_DELETE: begin
        if (p < 1 || p > list_len) begin
          r.status = pli_pkg::STATUS_BAD_POSITION;
        end else begin
          r.element = list_words[p-1];
          for (int k = p; k < list_len; k++) list_words[k-1] = list_words[k];
          list_len--;
        end
      end
      pli_pkg::FUNC_READ: begin
        if (p < 1 || p > list_len) begin
          r.status = pli_pkg::STATUS_BAD_POSITION;
        end else begin
          r.element = list_words[p-1];
        end
      end
      default: begin
        list_len = 0;
      end
    endcase
    r.list_length = pli_pkg::LENGTH_WIDTH'(list_len);
    return r;
  endfunction

  task automatic send_op(pli_pkg::func_t op, int pos,
                         logic signed [pli_pkg::VALUE_WIDTH-1:0] val);
    logic [pli_pkg::POSITION_WIDTH-1:0] pos_bits;
    pos_bits = pli_pkg::POSITION_WIDTH'(pos);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 38) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid    = 1'b1;
    req.func     = op;
    req.position = pos_bits;
    req.value    = val;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(apply_list_op(op, pos_bits, val));
    items_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    req.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        rsp.ready = 1'b0;
        hold_off_cycles--;
      end else begin
        rsp.ready = no_idle || ($urandom_range(99) >= 38);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result item with no operation outstanding");
      end else begin
        due = pending_results.pop_front();
        results_checked++;
        if (rsp.status !== due.status) begin
          flag_mismatch($sformatf("status %0d, wanted %0d", rsp.status, due.status));
        end
        if (rsp.element !== due.element) begin
          flag_mismatch($sformatf("element %0d, wanted %0d", rsp.element, due.element));
        end
        if (rsp.list_length !== due.list_length) begin
          flag_mismatch($sformatf("length %0d, wanted %0d", rsp.list_length,
                                  due.list_length));
        end
      end
    end
  end

  task automatic test_empty_list();
    send_op(pli_pkg::FUNC_READ, 1, 0);
    send_op(pli_pkg::FUNC_DELETE, 0, 0);
    send_op(pli_pkg::FUNC_INSERT, 2, 32'sd5);
    send_op(pli_pkg::FUNC_INSERT, 0, 32'sd5);
    send_op(pli_pkg::FUNC_READ, 511, 0);
    send_op(pli_pkg::FUNC_DELETE, 256, 0);
    wait_drain();
  endtask

  task automatic test_each_operation();
    send_op(pli_pkg::FUNC_INSERT, 1, 32'sh7FFF_FFFF);
    send_op(pli_pkg::FUNC_INSERT, 1, 32'sh8000_0000);
    send_op(pli_pkg::FUNC_INSERT, 3, -32'sd1);
    send_op(pli_pkg::FUNC_INSERT, 2, 32'sd0);
    send_op(pli_pkg::FUNC_READ, 1, 0);
    send_op(pli_pkg::FUNC_READ, 4, 0);
    send_op(pli_pkg::FUNC_READ, 5, 0);
    send_op(pli_pkg::FUNC_DELETE, 2, 0);
    send_op(pli_pkg::FUNC_DELETE, 3, 0);
    send_op(pli_pkg::FUNC_READ, 2, 0);
    send_op(pli_pkg::FUNC_DELETE, 1, 0);
    send_op(pli_pkg::FUNC_CLEAR, 0, 0);
    send_op(pli_pkg::FUNC_READ, 1, 0);
    send_op(pli_pkg::FUNC_INSERT, 1, 32'sh5555_5555);
    send_op(pli_pkg::FUNC_INSERT, 2, 32'shAAAA_AAAA);
    send_op(pli_pkg::FUNC_DELETE, 2, 0);
    send_op(pli_pkg::FUNC_CLEAR, 511, -32'sd1);
    wait_drain();
  endtask

  task automatic test_full_list();
    while (list_len < LIST_CAPACITY) begin
      send_op(pli_pkg::FUNC_INSERT,
              ($urandom_range(3) == 0) ? $urandom_range(list_len + 1, 1) : list_len + 1,
              $urandom);
    end
    send_op(pli_pkg::FUNC_INSERT, 257, $urandom);
    send_op(pli_pkg::FUNC_INSERT, 1, $urandom);
    send_op(pli_pkg::FUNC_INSERT, 258, $urandom);
    send_op(pli_pkg::FUNC_INSERT, 0, $urandom);
    send_op(pli_pkg::FUNC_READ, 256, 0);
    send_op(pli_pkg::FUNC_READ, 257, 0);
    send_op(pli_pkg::FUNC_DELETE, 256, 0);
    send_op(pli_pkg::FUNC_DELETE, 1, 0);
    send_op(pli_pkg::FUNC_INSERT, 1, $urandom);
    send_op(pli_pkg::FUNC_READ, 1, 0);
    send_op(pli_pkg::FUNC_INSERT, 128, $urandom);
    wait_drain();
  endtask

  task automatic test_result_stall();
    send_op(pli_pkg::FUNC_CLEAR, 0, 0);
    wait_drain();
    hold_off_cycles = 300;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2) begin
        send_op(pli_pkg::FUNC_READ, $urandom_range(list_len + 1, 0), 0);
      end else begin
        send_op(pli_pkg::FUNC_INSERT, $urandom_range(list_len + 1, 1), $urandom);
      end
    end
    wait_drain();
  endtask

  task automatic test_random_mix(int n_items);
    int unsigned roll;
    pli_pkg::func_t op;
    int pos;
    for (int i = 0; i < n_items; i++) begin
      no_idle = (i >= 400 && i < 550);
      roll = $urandom_range(99);
      if (i < n_items / 2) begin
        op = (roll < 52) ? pli_pkg::FUNC_INSERT :
             (roll < 72) ? pli_pkg::FUNC_DELETE : pli_pkg::FUNC_READ;
      end else begin
        op = (roll < 37) ? pli_pkg::FUNC_INSERT : (roll < 72) ? pli_pkg::FUNC_DELETE :
             (roll < 98) ? pli_pkg::FUNC_READ : pli_pkg::FUNC_CLEAR;
      end
      if (op == pli_pkg::FUNC_CLEAR || $urandom_range(99) < 7) begin
        case ($urandom_range(2))
          0:       pos = 0;
          1:       pos = list_len + 2;
          default: pos = $urandom_range(511);
        endcase
      end else if (op == pli_pkg::FUNC_INSERT) begin
        pos = $urandom_range(list_len + 1, 1);
      end else begin
        pos = (list_len == 0) ? 1 : $urandom_range(list_len, 1);
      end
      send_op(op, pos, $urandom);
    end
    no_idle = 1'b0;
    wait_drain();
  endtask

  initial begin
    rst             = 1'b1;
    req.valid       = 1'b0;
    req.func        = pli_pkg::FUNC_INSERT;
    req.position    = '0;
    req.value       = '0;
    list_len        = 0;
    error_count     = 0;
    items_sent      = 0;
    results_checked = 0;
    hold_off_cycles = 0;
    no_idle         = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    test_empty_list();
    test_each_operation();
    test_full_list();
    test_result_stall();
    test_random_mix(700);

    wait_drain();
    repeat (LIST_CAPACITY + 8) @(posedge clk);
    $display("Sent %0d operation items and checked %0d results, with a full list,",
             items_sent, results_checked);
    $display("bad positions, clears and a long result stall among them.");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: positional_list_insert_delete_core.f
hdl/pli_pkg.sv
hdl/pli_req_if.sv
hdl/pli_rsp_if.sv
hdl/positional_list_insert_delete_core.sv
sim/positional_list_insert_delete_core_tb.sv
